/* rtl/core/pdi_pkg.sv */
// shared types and constants for the path distance interpolator
package pdi_pkg;
  localparam int COORD_W = 32;
  localparam int IDX_W = 10;
  localparam int OUTC_W = 3;
  localparam int LEN_W = 11;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_EMPTY  = 3'd0,
    OUTC_SINGLE = 3'd1,
    OUTC_NAN    = 3'd2,
    OUTC_BEFORE = 3'd3,
    OUTC_PAST   = 3'd4,
    OUTC_INTERP = 3'd5
  } outcome_t;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } waypoint_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W+1:0] v);
    if (v > $signed({3'b000, {(COORD_W-1){1'b1}}})) begin
      sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < $signed({3'b111, {(COORD_W-1){1'b0}}})) begin
      sat32 = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction
endpackage

/* rtl/core/pdi_if.sv */
// valid/ready channel interfaces for requests and results
interface pdi_req_if;
  import pdi_pkg::*;
  logic valid;
  logic ready;
  logic req_type;
  logic [IDX_W-1:0] entry_index;
  logic signed [COORD_W-1:0] entry_distance;
  logic signed [COORD_W-1:0] entry_x;
  logic signed [COORD_W-1:0] entry_y;
  logic signed [COORD_W-1:0] entry_z;
  logic signed [COORD_W-1:0] odometer;
  logic signed [COORD_W-1:0] offset;
  logic offset_is_nan;
  logic [IDX_W-1:0] start_index;
  modport source(output valid, req_type, entry_index, entry_distance, entry_x, entry_y,
                 entry_z, odometer, offset, offset_is_nan, start_index, input ready);
  modport sink(input valid, req_type, entry_index, entry_distance, entry_x, entry_y,
               entry_z, odometer, offset, offset_is_nan, start_index, output ready);
endinterface

interface pdi_res_if;
  import pdi_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [IDX_W-1:0] segment;
  logic [OUTC_W-1:0] outcome;
  modport source(output valid, pos_x, pos_y, pos_z, segment, outcome, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, segment, outcome, output ready);
endinterface

/* rtl/core/pdi_table.sv */
// waypoint table memory, one write port and one registered read port
module pdi_table
  import pdi_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  waypoint_t       wdata,
  input  logic [AW-1:0]   raddr,
  output waypoint_t       rdata
);
  waypoint_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/pdi_divider.sv */
// restoring divider, one quotient bit per cycle, quotient saturated to 17 bits
module pdi_divider
  import pdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COORD_W:0]  num,
  input  logic [COORD_W:0]  den,
  output logic              done,
  output logic [16:0]       quot
);
  localparam int NB = COORD_W + 17;
  localparam int CW = $clog2(NB + 1);
  logic [NB-1:0] dividend;
  logic [COORD_W+1:0] rem;
  logic [COORD_W:0] dsr;
  logic [NB-1:0] q;
  logic [CW-1:0] cnt;
  logic busy;
  logic [COORD_W+1:0] trial;

  assign trial = {rem[COORD_W:0], dividend[NB-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(NB);
        dividend <= {num, 16'd0};
        rem <= '0;
        dsr <= den;
        q <= '0;
      end else if (busy) begin
        dividend <= {dividend[NB-2:0], 1'b0};
        if (!trial[COORD_W+1]) begin
          rem <= trial;
          q <= {q[NB-2:0], 1'b1};
        end else begin
          rem <= {rem[COORD_W:0], dividend[NB-1]};
          q <= {q[NB-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // clamp to 1.0 in q1.16
  assign quot = (|q[NB-1:17] || q[16]) ? 17'h10000 : q[16:0];
endmodule

/* rtl/core/path_distance_interpolator_top.sv */
// top level of the path distance interpolator
// Holds up to MAX_WAYPOINTS waypoints (cumulative distance and x/y/z, signed q16.16) and
// answers query words with the position at odometer+offset along the path. A load word
// is written to the table when it is accepted, and loads can follow back to back. A query
// reads the table one entry at a time through a single registered read port, scanning
// from start_index to the bracketing segment. A result is raised for an empty path, a
// single waypoint, a nan offset, a goal at or before the first waypoint, a goal at or
// past the last one, or an interpolated answer. For an interpolated answer a serial
// divide step forms the q1.16 fraction bit by bit; a zero or negative numerator or
// segment length skips it with a zero fraction. One shared multiplier then handles x,
// y and z in turn, issuing each product and then folding it in. The request side is
// not ready while a word is in work or a result waits to be taken. No clearing pass;
// entries read before being written return undefined data.
module path_distance_interpolator_top
  import pdi_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LEN_W-1:0]   cfg_wdata,
  pdi_req_if.sink            req,
  pdi_res_if.source          res
);
  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int NW = $clog2(MAX_WAYPOINTS + 1) > LEN_W ? $clog2(MAX_WAYPOINTS + 1) : LEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_CHK, S_FWD, S_BWD, S_HI, S_DIV, S_MUL, S_OUT
  } state_t;
  state_t state;

  logic [LEN_W-1:0] path_length;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_last;
  assign n_eff = ({{(NW-LEN_W){1'b0}}, path_length} > NW'(MAX_WAYPOINTS)) ?
                 NW'(MAX_WAYPOINTS) : {{(NW-LEN_W){1'b0}}, path_length};
  assign n_last = n_eff - 1'b1;

  // table
  logic we;
  logic [AW-1:0] raddr;
  waypoint_t rdata, wdata;
  assign we = req.valid && req.ready && req.req_type == REQ_LOAD &&
              ({{(NW-IDX_W){1'b0}}, req.entry_index} < NW'(MAX_WAYPOINTS));
  assign wdata = '{d: req.entry_distance, x: req.entry_x, y: req.entry_y, z: req.entry_z};

  pdi_table #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(req.entry_index[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // divider
  logic div_start, div_done;
  logic [COORD_W:0] div_num, div_den;
  logic [16:0] frac_q;
  pdi_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(frac_q)
  );

  // query context
  logic signed [COORD_W-1:0] goal;
  logic nan_q;
  logic [NW-1:0] lo;          // current scan index
  logic [1:0] phase;          // which read is in flight during S_CHK
  waypoint_t w_lo, w_hi;
  logic [16:0] frac;
  logic [1:0] mcnt;
  logic signed [COORD_W-1:0] px, py, pz;
  logic [IDX_W-1:0] seg;
  outcome_t outc;

  logic signed [COORD_W+1:0] goal_sum;
  assign goal_sum = {{2{req.odometer[COORD_W-1]}}, req.odometer} +
                    {{2{req.offset[COORD_W-1]}}, req.offset};

  // shared multiplier: frac * (p1 - p0), registered
  logic signed [COORD_W:0] m_diff;
  logic signed [COORD_W+18:0] m_prod;
  logic signed [COORD_W-1:0] m_a;
  logic signed [COORD_W+18:0] m_sum;
  always_comb begin
    unique case (mcnt)
      2'd0: begin m_a = w_lo.x; m_diff = {w_hi.x[COORD_W-1], w_hi.x} - {w_lo.x[COORD_W-1], w_lo.x}; end
      2'd1: begin m_a = w_lo.y; m_diff = {w_hi.y[COORD_W-1], w_hi.y} - {w_lo.y[COORD_W-1], w_lo.y}; end
      default: begin m_a = w_lo.z; m_diff = {w_hi.z[COORD_W-1], w_hi.z} - {w_lo.z[COORD_W-1], w_lo.z}; end
    endcase
  end
  // round half up then floor by arithmetic shift
  assign m_sum = m_prod + (COORD_W+19)'(32768);
  logic signed [COORD_W+1:0] m_res;
  assign m_res = {{2{m_a[COORD_W-1]}}, m_a} + m_sum[COORD_W+17:16];

  logic [COORD_W:0] num_w;
  logic [COORD_W:0] dd_w;
  assign num_w = {goal[COORD_W-1], goal} - {w_lo.d[COORD_W-1], w_lo.d};
  assign dd_w = {w_hi.d[COORD_W-1], w_hi.d} - {w_lo.d[COORD_W-1], w_lo.d};
  assign div_num = num_w;
  assign div_den = dd_w;

  assign req.ready = (state == S_IDLE) && !res.valid;

  logic [NW-1:0] start_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      path_length <= '0;
      res.valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        path_length <= cfg_wdata;
      end
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready && req.req_type == REQ_QUERY) begin
            goal <= sat32(goal_sum);
            nan_q <= req.offset_is_nan;
            start_clamp <= {{(NW-IDX_W){1'b0}}, req.start_index};
            state <= S_RD;
          end
        end
        S_RD: begin
          // single and nan cases resolve on a single read; an empty path needs none
          if (n_eff == '0) begin
            px <= '0; py <= '0; pz <= '0; seg <= '0; outc <= OUTC_EMPTY;
            state <= S_OUT;
          end else begin
            if (n_eff == NW'(1)) begin
              lo <= '0; outc <= OUTC_SINGLE;
              raddr <= '0;
            end else if (nan_q) begin
              lo <= (start_clamp > n_last) ? n_last : start_clamp;
              raddr <= AW'((start_clamp > n_last) ? n_last : start_clamp);
              outc <= OUTC_NAN;
            end else begin
              raddr <= '0;
              outc <= OUTC_INTERP;
            end
            phase <= 2'd0;
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_CHK;
        S_CHK: begin
          if (outc != OUTC_INTERP) begin
            px <= rdata.x; py <= rdata.y; pz <= rdata.z; seg <= IDX_W'(lo);
            state <= S_OUT;
          end else if (phase == 2'd0) begin
            if (goal <= rdata.d) begin
              px <= rdata.x; py <= rdata.y; pz <= rdata.z; seg <= '0;
              outc <= OUTC_BEFORE;
              state <= S_OUT;
            end else begin
              raddr <= AW'(n_last);
              phase <= 2'd1;
              state <= S_WAIT;
            end
          end else if (phase == 2'd1) begin
            if (goal >= rdata.d) begin
              px <= rdata.x; py <= rdata.y; pz <= rdata.z; seg <= IDX_W'(n_last);
              outc <= OUTC_PAST;
              state <= S_OUT;
            end else begin
              lo <= (start_clamp > n_last - 1'b1) ? n_last - 1'b1 : start_clamp;
              raddr <= AW'(((start_clamp > n_last - 1'b1) ? n_last - 1'b1 : start_clamp) + 1'b1);
              phase <= 2'd2;
              state <= S_WAIT;
            end
          end else begin
            // forward scan: read lo+1
            if (lo < n_last - 1'b1 && rdata.d <= goal) begin
              lo <= lo + 1'b1;
              raddr <= AW'(lo + 2'd2);
              state <= S_WAIT;
            end else begin
              raddr <= AW'(lo);
              state <= S_FWD;
            end
          end
        end
        S_FWD: state <= S_BWD;
        S_BWD: begin
          // rdata holds entry lo; walk back while it lies past the goal
          if (lo > '0 && rdata.d > goal) begin
            lo <= lo - 1'b1;
            raddr <= AW'(lo - 1'b1);
            state <= S_FWD;
          end else begin
            w_lo <= rdata;
            raddr <= AW'(lo + 1'b1);
            phase <= 2'd0;
            state <= S_HI;
          end
        end
        S_HI: begin
          if (phase == 2'd0) begin
            phase <= 2'd1;
          end else begin
            w_hi <= rdata;
            phase <= 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (phase == 2'd0) begin
            if ($signed(dd_w) <= 0 || $signed(num_w) <= 0) begin
              frac <= '0;
              mcnt <= 2'd0;
              phase <= 2'd2;
              state <= S_MUL;
            end else begin
              div_start <= 1'b1;
              phase <= 2'd1;
            end
          end else if (div_done) begin
            frac <= frac_q;
            mcnt <= 2'd0;
            phase <= 2'd2;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // phase 2 issues a product, phase 3 folds it in
          if (phase == 2'd2) begin
            m_prod <= $signed({1'b0, frac}) * m_diff;
            phase <= 2'd3;
          end else begin
            unique case (mcnt)
              2'd0: px <= sat32(m_res);
              2'd1: py <= sat32(m_res);
              default: pz <= sat32(m_res);
            endcase
            phase <= 2'd2;
            if (mcnt == 2'd2) begin
              seg <= IDX_W'(lo);
              state <= S_OUT;
            end else begin
              mcnt <= mcnt + 1'b1;
            end
          end
        end
        S_OUT: begin
          res.valid <= 1'b1;
          res.pos_x <= px; res.pos_y <= py; res.pos_z <= pz;
          res.segment <= seg; res.outcome <= outc;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.pos_x) && $stable(res.outcome))
    else $error("result changed while stalled");
  // no new request accepted while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready)
    else $error("request accepted with result pending");
  // divider only runs in the divide state
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");
endmodule
